### design/slts_pkg.sv
// Shared types, character constants and matcher tables for the token scanner.
// Used by slts_scan, slts_tok_queue and small_language_token_scanner_core.
package slts_pkg;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_INTEGER = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_DELIM   = 3'd4,
    KIND_ASSIGN  = 3'd5,
    KIND_END     = 3'd6,
    KIND_ERROR   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code;
    logic [15:0] line_no;
    logic [15:0] column;
    logic [7:0]  length;
  } tok_t;

  // Results of one input beat: t0 always present, t1 only when two is set.
  typedef struct packed {
    logic two;
    tok_t t0;
    tok_t t1;
  } tok_pair_t;

  localparam int TokWidth   = 51;
  localparam int TdataWidth = 56;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [5:0] KW_START = 6'd0;
  localparam logic [5:0] KW_DEAD  = 6'd63;
  localparam logic [3:0] OP_START = 4'd0;
  localparam logic [3:0] OP_DEAD  = 4'd15;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_opch(input logic [7:0] c);
    return c == "=" || c == "!" || c == "<" || c == ">" ||
           c == "/" || c == "+" || c == "-" || c == "*";
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || is_opch(c);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == "(" || c == ")" || c == "{" || c == "}" ||
           c == ";" || c == ":" || c == ",";
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] r;
    case (k)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd4;
      3'd5:    r = 3'd5;
      3'd6:    r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

  // Byte p of keyword k; text is left-justified, padding is never compared.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] t;
    logic [2:0]  idx;
    case (k)
      3'd0:    t = "func....";
      3'd1:    t = "var.....";
      3'd2:    t = "let.....";
      3'd3:    t = "if......";
      3'd4:    t = "else....";
      3'd5:    t = "while...";
      3'd6:    t = "print...";
      default: t = "return..";
    endcase
    idx = 3'd7 - p;
    return t[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [5:0] kw_next(input logic [5:0] s, input logic [7:0] c);
    logic [5:0] r;
    logic [2:0] k;
    logic [2:0] p;
    r = KW_DEAD;
    k = s[5:3];
    p = s[2:0];
    if (s == KW_DEAD) begin
      r = KW_DEAD;
    end else if (s == KW_START) begin
      for (int i = 7; i >= 0; i--) begin
        if (kw_char(3'(i), 3'd0) == c) r = {3'(i), 3'd1};
      end
    end else if (p < kw_len(k) && kw_char(k, p) == c) begin
      r = s + 6'd1;
    end
    return r;
  endfunction

  function automatic logic [3:0] op_next(input logic [3:0] s, input logic [7:0] c);
    logic [3:0] r;
    r = OP_DEAD;
    if (s == OP_START) begin
      case (c)
        "=":     r = 4'd1;
        "!":     r = 4'd2;
        "<":     r = 4'd3;
        ">":     r = 4'd4;
        "/":     r = 4'd5;
        "+":     r = 4'd6;
        "-":     r = 4'd7;
        "*":     r = 4'd8;
        default: r = OP_DEAD;
      endcase
    end else if (c == CH_EQ && s inside {[4'd1:4'd4]}) begin
      r = s + 4'd8;
    end
    return r;
  endfunction

  // Operator state to operator index plus one; zero means not accepting.
  function automatic logic [3:0] op_accept(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      4'd3:    r = 4'd5;
      4'd4:    r = 4'd6;
      4'd5:    r = 4'd7;
      4'd6:    r = 4'd8;
      4'd7:    r = 4'd9;
      4'd8:    r = 4'd10;
      4'd9:    r = 4'd1;
      4'd10:   r = 4'd2;
      4'd11:   r = 4'd3;
      4'd12:   r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### design/small_language_token_scanner_core.sv
// Token scanner core: one source byte per beat, tokens out one per beat.
// A token is written to the registered result queue on the beat that closes it.
// One input byte per cycle while the result queue has space; an end beat that also
// closes a token yields two tokens, handed out one per beat, and can stall the input.
// Reset (rst_n low, synchronous) returns to line 1, column 0, no held byte,
// and clears the halt after an error; the result queue is emptied.
module small_language_token_scanner_core import slts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // ch[7:0]
  input  logic                  in_tlast,   // is_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TdataWidth-1:0] out_tdata,  // kind[2:0], code, line_no, column, length
  output logic                  out_tlast   // last
);

  logic      space, push, beat_in;
  tok_pair_t push_pair;
  tok_t      tok;

  assign in_tready = space;
  assign beat_in   = in_tvalid & space;

  slts_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_in   (beat_in),
    .ch        (in_tdata),
    .is_end    (in_tlast),
    .push      (push),
    .push_pair (push_pair)
  );

  slts_tok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok),
    .out_last  (out_tlast)
  );

  // pack fields lowest first: kind, code, line_no, column, length
  assign out_tdata = {{(TdataWidth - TokWidth){1'b0}}, tok.length, tok.column,
                      tok.line_no, tok.code, tok.kind};

endmodule

### design/slts_scan.sv
// Scanner state registers and the per-byte update with one byte of lookahead.
// Depends on slts_pkg for character classes, matcher tables and token types.
module slts_scan import slts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      beat_in,
  input  logic [7:0] ch,
  input  logic      is_end,
  output logic      push,
  output tok_pair_t push_pair
);

  logic [7:0]  held_char_r, held_char_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        in_comment_r, in_comment_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] begin_r, begin_nxt;
  logic [7:0]  wlen_r, wlen_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [5:0]  kw_r, kw_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        halted_r, halted_nxt;

  logic        consumed, halt_v, pv, ev;
  tok_t        pt, et;
  logic [15:0] col1, wbeg;
  logic [1:0]  fl;
  logic [5:0]  kwb, kwn;
  logic [3:0]  opb, opn, opa;
  logic [7:0]  wlb, wln;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      in_comment_r <= 1'b0;
      line_r       <= 16'd1;
      col_r        <= '0;
      begin_r      <= '0;
      wlen_r       <= '0;
      flags_r      <= 2'b11;
      kw_r         <= KW_START;
      op_r         <= OP_START;
      halted_r     <= 1'b0;
    end else begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      in_comment_r <= in_comment_nxt;
      line_r       <= line_nxt;
      col_r        <= col_nxt;
      begin_r      <= begin_nxt;
      wlen_r       <= wlen_nxt;
      flags_r      <= flags_nxt;
      kw_r         <= kw_nxt;
      op_r         <= op_nxt;
      halted_r     <= halted_nxt;
    end
  end

  always_comb begin
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    in_comment_nxt = in_comment_r;
    line_nxt       = line_r;
    col_nxt        = col_r;
    begin_nxt      = begin_r;
    wlen_nxt       = wlen_r;
    flags_nxt      = flags_r;
    kw_nxt         = kw_r;
    op_nxt         = op_r;
    halted_nxt     = halted_r;
    consumed       = 1'b0;
    halt_v         = halted_r;
    pv             = 1'b0;
    ev             = 1'b0;
    pt             = '0;
    et             = '0;
    col1           = sat_inc16(col_r);
    wbeg           = begin_r;
    fl             = flags_r;
    kwb            = kw_r;
    opb            = op_r;
    wlb            = wlen_r;
    kwn            = kw_r;
    opn            = op_r;
    opa            = '0;
    wln            = wlen_r;

    if (beat_in && !halted_r) begin
      if (held_valid_r) begin
        col_nxt = col1;
        if (held_char_r == CH_NL) begin
          line_nxt       = sat_inc16(line_r);
          col_nxt        = '0;
          in_comment_nxt = 1'b0;
        end else if (in_comment_r || held_char_r == CH_SP || held_char_r == CH_CR ||
                     held_char_r == CH_TAB) begin
          // skip
        end else if (held_char_r == CH_HASH) begin
          in_comment_nxt = 1'b1;
        end else if (!is_wordch(held_char_r) && !is_delim(held_char_r)) begin
          pv     = 1'b1;
          pt     = '{KIND_ERROR, 8'd0, line_r, col1, 8'd0};
          halt_v = 1'b1;
        end else if (is_delim(held_char_r)) begin
          pv = 1'b1;
          if (held_char_r == CH_COLON && !is_end && ch == CH_EQ) begin
            // swallow the lookahead '=' together with the ':'
            consumed = 1'b1;
            col_nxt  = sat_inc16(col1);
            pt       = '{KIND_ASSIGN, 8'd0, line_r, col1, 8'd2};
          end else begin
            pt = '{KIND_DELIM, held_char_r, line_r, col1, 8'd1};
          end
        end else begin
          if (wlen_r == 8'd0) begin
            wbeg = col1;
            fl   = {1'b1, is_alpha(held_char_r)};
            kwb  = KW_START;
            opb  = OP_START;
            wlb  = '0;
          end else if (!is_alpha(held_char_r) && !is_digit(held_char_r)) begin
            fl[0] = 1'b0;
          end
          if (!is_digit(held_char_r)) fl[1] = 1'b0;
          kwn = kw_next(kwb, held_char_r);
          opn = op_next(opb, held_char_r);
          wln = (wlb == 8'hFF) ? wlb : wlb + 8'd1;
          opa = op_accept(opn);
          begin_nxt = wbeg;
          flags_nxt = fl;
          kw_nxt    = kwn;
          op_nxt    = opn;
          wlen_nxt  = wln;
          if (is_end || !is_wordch(ch)) begin
            // close the word and class it
            pv = 1'b1;
            if (kwn != KW_START && kwn != KW_DEAD && kwn[2:0] == kw_len(kwn[5:3])) begin
              pt = '{KIND_KEYWORD, {5'd0, kwn[5:3]}, line_r, wbeg, wln};
            end else if (fl[0]) begin
              pt = '{KIND_IDENT, 8'd0, line_r, wbeg, wln};
            end else if (fl[1]) begin
              pt = '{KIND_INTEGER, 8'd0, line_r, wbeg, wln};
            end else if (opa != 4'd0) begin
              pt = '{KIND_OPER, {4'd0, opa - 4'd1}, line_r, wbeg, wln};
            end else begin
              pt     = '{KIND_ERROR, 8'd0, line_r, col1, 8'd0};
              halt_v = 1'b1;
            end
            wlen_nxt  = '0;
            flags_nxt = 2'b11;
            kw_nxt    = KW_START;
            op_nxt    = OP_START;
          end
        end
      end

      if (!halt_v) begin
        if (is_end) begin
          ev             = 1'b1;
          et             = '{KIND_END, 8'd0, line_nxt, col_nxt, 8'd0};
          held_valid_nxt = 1'b0;
          in_comment_nxt = 1'b0;
          wlen_nxt       = '0;
          flags_nxt      = 2'b11;
          kw_nxt         = KW_START;
          op_nxt         = OP_START;
        end else if (consumed) begin
          held_valid_nxt = 1'b0;
        end else begin
          held_char_nxt  = ch;
          held_valid_nxt = 1'b1;
        end
      end
      halted_nxt = halt_v;
    end

    push           = pv | ev;
    push_pair.two  = pv & ev;
    push_pair.t0   = pv ? pt : et;
    push_pair.t1   = et;
  end

endmodule

### design/slts_tok_queue.sv
// Two-entry result queue that holds the token pair of each input beat
// and hands the tokens out one beat at a time. Depends on slts_pkg.
module slts_tok_queue import slts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_pair_t push_pair,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_t      out_tok,
  output logic      out_last
);

  tok_pair_t  q_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic       sel_r, sel_nxt;
  logic [1:0] count_r, count_nxt;
  tok_pair_t  head_pair;
  logic       beat, pop;

  assign head_pair = q_r[head_r];
  assign space     = count_r != 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_tok   = sel_r ? head_pair.t1 : head_pair.t0;
  assign out_last  = sel_r | ~head_pair.two;
  assign beat      = out_valid & out_ready;
  assign pop       = beat & out_last;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    sel_nxt   = sel_r;
    count_nxt = count_r;
    if (beat) sel_nxt = ~pop;
    if (pop) head_nxt = ~head_r;
    if (push) tail_nxt = ~tail_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      sel_r   <= 1'b0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      sel_r   <= sel_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[tail_r] <= push_pair;
  end

endmodule
